@@ src/fbpa_pkg.sv @@
package fbpa_pkg;

    // pool sizing
    localparam int unsigned SMALL_COUNT  = 8;
    localparam int unsigned MID_COUNT    = 8;
    localparam int unsigned LARGE_COUNT  = 4;
    localparam int unsigned HEADER_BYTES = 8;

    localparam int unsigned POOL_COUNT   = 3;
    localparam int unsigned TOTAL_BLOCKS = SMALL_COUNT + MID_COUNT + LARGE_COUNT;

    // block index carries the null link, link array index does not
    localparam int unsigned IDX_W   = $clog2(TOTAL_BLOCKS + 1);
    localparam int unsigned LINK_AW = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int unsigned POOL_W  = 2;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned REQ_W   = 16;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [IDX_W-1:0]   blk_idx_t;
    typedef logic [POOL_W-1:0]  pool_idx_t;

    localparam blk_idx_t NULL_LINK = blk_idx_t'(TOTAL_BLOCKS);

    localparam pool_idx_t POOL_SMALL = 2'd0;
    localparam pool_idx_t POOL_MID   = 2'd1;
    localparam pool_idx_t POOL_LARGE = 2'd2;

    localparam addr_t CLASS_BYTES [POOL_COUNT] = '{addr_t'(16), addr_t'(32), addr_t'(64)};
    localparam int unsigned CLASS_SHIFT [POOL_COUNT] = '{4, 5, 6};

    localparam addr_t POOL_FIRST [POOL_COUNT] = '{
        addr_t'(0),
        addr_t'(SMALL_COUNT),
        addr_t'(SMALL_COUNT + MID_COUNT)
    };

    localparam addr_t POOL_OFFSET [POOL_COUNT] = '{
        addr_t'(0),
        addr_t'(SMALL_COUNT * 16),
        addr_t'(SMALL_COUNT * 16 + MID_COUNT * 32)
    };

    localparam addr_t POOL_END [POOL_COUNT] = '{
        addr_t'(SMALL_COUNT * 16),
        addr_t'(SMALL_COUNT * 16 + MID_COUNT * 32),
        addr_t'(SMALL_COUNT * 16 + MID_COUNT * 32 + LARGE_COUNT * 64)
    };

    // largest usable request per class
    localparam addr_t FIT_LIMIT [POOL_COUNT] = '{
        addr_t'(16 - HEADER_BYTES),
        addr_t'(32 - HEADER_BYTES),
        addr_t'(64 - HEADER_BYTES)
    };

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FIT   = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_BAD_ADDR = 2'd3
    } status_t;

    // decoded transaction handed to the free list
    typedef struct packed {
        mode_t     mode;
        logic      fit;
        pool_idx_t alloc_pool;
        logic      hit;
        pool_idx_t free_pool;
        blk_idx_t  free_idx;
    } fbpa_req_t;

    typedef struct packed {
        status_t status;
        addr_t   address;
    } fbpa_rsp_t;

    // reset link of a block: next block of its pool, null at the pool's end
    function automatic blk_idx_t link_reset(input int unsigned i);
        blk_idx_t link;
        if (i == SMALL_COUNT - 1 || i == SMALL_COUNT + MID_COUNT - 1
            || i == TOTAL_BLOCKS - 1)
        begin
            link = NULL_LINK;
        end
        else
        begin
            link = blk_idx_t'(i + 1);
        end
        return link;
    endfunction

endpackage

@@ src/fixed_block_pool_allocator.sv @@
// channel   direction  handshake             payload
// in        input      in_valid / in_stall    mode, request_bytes, block_address
// out       output     out_valid / out_stall  result_address, status
// cfg       input      cfg_we                 cfg_wdata (base_address)
//
// every transaction passes from the input register to the result register;
// a new transaction is taken every cycle unless out_stall holds a result;
// free list heads and links live in flops and are updated as the result
// register loads
// reset puts every block on its pool's free list in address order and clears
// base_address to zero; no clearing pass is needed
// a stalled result holds the input register, which then stalls the input
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [15:0]       request_bytes,
    input  logic [31:0]       block_address,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       result_address,
    output logic [1:0]        status
);

    // configuration
    addr_t             base_reg;

    // input register
    logic              in_full_reg;
    logic              in_full_next;
    logic              mode_reg;
    logic [REQ_W-1:0]  req_bytes_reg;
    addr_t             blk_addr_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    addr_t             result_address_reg;
    status_t           status_reg;

    logic              advance;
    logic              in_take;
    logic              op_en;
    fbpa_req_t         dec_req;
    fbpa_rsp_t         rsp;

    // result register frees up when empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign op_en    = in_full_reg && advance;

    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = op_en || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg      <= mode;
            req_bytes_reg <= request_bytes;
            blk_addr_reg  <= block_address;
        end
        if (op_en)
        begin
            result_address_reg <= rsp.address;
            status_reg         <= rsp.status;
        end
    end

    // size class pick and free address decode
    fbpa_classify u_classify (
        .mode          (mode_reg),
        .request_bytes (req_bytes_reg),
        .block_address (blk_addr_reg),
        .base_address  (base_reg),
        .req           (dec_req)
    );

    // per-pool free lists, head pop on alloc and head push on free
    fbpa_free_list u_free_list (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_en        (op_en),
        .req          (dec_req),
        .base_address (base_reg),
        .rsp          (rsp)
    );

    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign status         = status_reg;

endmodule

@@ src/fbpa_classify.sv @@
module fbpa_classify
    import fbpa_pkg::*;
(
    input  logic              mode,
    input  logic [REQ_W-1:0]  request_bytes,
    input  addr_t             block_address,
    input  addr_t             base_address,
    output fbpa_req_t         req
);

    addr_t req_ext;
    addr_t off;
    addr_t rel;

    assign req_ext = addr_t'(request_bytes);
    // data address back to header offset inside the pool area
    assign off = block_address - addr_t'(HEADER_BYTES) - base_address;

    always_comb
    begin
        req.mode       = mode_t'(mode);
        req.fit        = 1'b1;
        req.alloc_pool = POOL_SMALL;
        priority if (req_ext <= FIT_LIMIT[0])
        begin
            req.alloc_pool = POOL_SMALL;
        end
        else if (req_ext <= FIT_LIMIT[1])
        begin
            req.alloc_pool = POOL_MID;
        end
        else if (req_ext <= FIT_LIMIT[2])
        begin
            req.alloc_pool = POOL_LARGE;
        end
        else
        begin
            req.fit = 1'b0;
        end

        req.hit       = 1'b0;
        req.free_pool = POOL_SMALL;
        req.free_idx  = blk_idx_t'(0);
        rel           = '0;
        priority if (off < POOL_END[0])
        begin
            rel           = off - POOL_OFFSET[0];
            req.free_pool = POOL_SMALL;
            req.hit       = (rel & (CLASS_BYTES[0] - addr_t'(1))) == '0;
            req.free_idx  = blk_idx_t'(POOL_FIRST[0] + (rel >> CLASS_SHIFT[0]));
        end
        else if (off < POOL_END[1])
        begin
            rel           = off - POOL_OFFSET[1];
            req.free_pool = POOL_MID;
            req.hit       = (rel & (CLASS_BYTES[1] - addr_t'(1))) == '0;
            req.free_idx  = blk_idx_t'(POOL_FIRST[1] + (rel >> CLASS_SHIFT[1]));
        end
        else if (off < POOL_END[2])
        begin
            rel           = off - POOL_OFFSET[2];
            req.free_pool = POOL_LARGE;
            req.hit       = (rel & (CLASS_BYTES[2] - addr_t'(1))) == '0;
            req.free_idx  = blk_idx_t'(POOL_FIRST[2] + (rel >> CLASS_SHIFT[2]));
        end
        else
        begin
            req.hit = 1'b0;
        end
    end

endmodule

@@ src/fbpa_free_list.sv @@
module fbpa_free_list
    import fbpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_en,
    input  fbpa_req_t req,
    input  addr_t     base_address,
    output fbpa_rsp_t rsp
);

    blk_idx_t  head_reg [POOL_COUNT];
    blk_idx_t  link_reg [TOTAL_BLOCKS];

    pool_idx_t pool;
    blk_idx_t  head;
    blk_idx_t  local_idx;
    logic      do_pop;
    logic      do_push;

    assign pool = (req.mode == MODE_FREE) ? req.free_pool : req.alloc_pool;

    always_comb
    begin
        unique case (pool)
            POOL_SMALL: head = head_reg[0];
            POOL_MID:   head = head_reg[1];
            POOL_LARGE: head = head_reg[2];
            default:    head = NULL_LINK;
        endcase
    end

    assign local_idx = blk_idx_t'(addr_t'(head) - POOL_FIRST[pool]);

    always_comb
    begin
        do_pop      = 1'b0;
        do_push     = 1'b0;
        rsp.address = '0;
        if (req.mode == MODE_ALLOC)
        begin
            priority if (!req.fit)
            begin
                rsp.status = STATUS_NO_FIT;
            end
            else if (head == NULL_LINK)
            begin
                rsp.status = STATUS_EMPTY;
            end
            else
            begin
                rsp.status  = STATUS_OK;
                do_pop      = 1'b1;
                rsp.address = base_address + POOL_OFFSET[pool] + addr_t'(HEADER_BYTES)
                            + (addr_t'(local_idx) << CLASS_SHIFT[pool]);
            end
        end
        else
        begin
            if (req.hit)
            begin
                rsp.status = STATUS_OK;
                do_push    = 1'b1;
            end
            else
            begin
                rsp.status = STATUS_BAD_ADDR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < POOL_COUNT; p++)
            begin
                head_reg[p] <= blk_idx_t'(POOL_FIRST[p]);
            end
            for (int i = 0; i < TOTAL_BLOCKS; i++)
            begin
                link_reg[i] <= link_reset(i);
            end
        end
        else if (op_en)
        begin
            if (do_pop)
            begin
                // head pop, popped block leaves with a null link
                head_reg[pool]                <= link_reg[head[LINK_AW-1:0]];
                link_reg[head[LINK_AW-1:0]]   <= NULL_LINK;
            end
            else if (do_push)
            begin
                link_reg[req.free_idx[LINK_AW-1:0]] <= head;
                head_reg[pool]                      <= req.free_idx;
            end
        end
    end

endmodule
